// ----- rtl/core/video_sync_pixel_capture_macros.svh -----
// Assertion macros shared by the video sync pixel capture checkers.
// Included by name from the checker file; no other dependencies.
`ifndef VIDEO_SYNC_PIXEL_CAPTURE_MACROS_SVH
`define VIDEO_SYNC_PIXEL_CAPTURE_MACROS_SVH

// Check a property while reset is low.
`define VSPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define VSPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/vspc_pkg.sv -----
// Package for the video sync pixel capture block: widths, register indexes,
// reset values, frame geometry and the fixed 32-entry colour palette.
// No dependencies.
package vspc_pkg;

  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned ADDR_W      = 18;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned BUF_W       = 3;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 18;
  localparam int unsigned PAL_IDX_W   = 5;

  localparam int unsigned LINE_PIXELS  = 800;
  localparam int unsigned FRAME_PIXELS = 249600;
  localparam int unsigned NUM_BUFFERS  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_SYNC = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HSYNC_RUN = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VSYNC_RUN = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RESTART   = 8'd3;

  localparam logic              SHOW_SYNC_RST = 1'b0;
  localparam logic [RUN_W-1:0]  HSYNC_RUN_RST = 8'h40;
  localparam logic [RUN_W-1:0]  VSYNC_RUN_RST = 8'h20;
  localparam logic [ADDR_W-1:0] RESTART_RST   = 18'd242336;

  localparam logic [COLOR_W-1:0] PALETTE [2**PAL_IDX_W] = '{
    24'h000000, 24'h800000, 24'h008000, 24'h808000,
    24'h000080, 24'h800080, 24'h008080, 24'h808080,
    24'h000000, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF,
    24'h005234, 24'h800000, 24'h008000, 24'h808000,
    24'h000080, 24'h800080, 24'h008080, 24'h808080,
    24'h005234, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  typedef struct packed {
    logic              show_sync;
    logic [RUN_W-1:0]  hsync_run;
    logic [RUN_W-1:0]  vsync_run;
    logic [ADDR_W-1:0] restart_address;
  } cfg_t;

endpackage

// ----- rtl/core/video_sync_pixel_capture.sv -----
// Top level: input register, address generator, palette and result register.
// Depends on vspc_pkg, vspc_cfg and vspc_addr_gen.
// A request's sample is held in the input register, then its result in the result register.
// Throughput: one request per cycle while results drain and cfg is not busy.
// A restart address write holds in_ready low until its column is computed.
// Reset: synchronous; restores registers, clears address, run count, buffer, valids.
module video_sync_pixel_capture #(
  parameter int unsigned LINE_PIXELS = vspc_pkg::LINE_PIXELS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vspc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vspc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [vspc_pkg::SAMPLE_W-1:0]       raw_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [vspc_pkg::BUF_W-1:0]          buffer_select,
  output logic [vspc_pkg::ADDR_W-1:0]         pixel_address,
  output logic [vspc_pkg::COLOR_W-1:0]        pixel_color,
  output logic                                frame_done
);

  localparam int unsigned COL_W = $clog2(LINE_PIXELS);

  vspc_pkg::cfg_t                      cfg;
  logic [COL_W-1:0]                    restart_col;
  logic                                cfg_busy;
  logic [vspc_pkg::SAMPLE_W-1:0]       sample_q;
  logic                                sample_valid;
  logic                                advance;
  logic [vspc_pkg::SAMPLE_W-1:0]       sample;
  logic [vspc_pkg::PAL_IDX_W-1:0]      pal_idx;
  logic [vspc_pkg::BUF_W-1:0]          buf_d;
  logic [vspc_pkg::ADDR_W-1:0]         addr_d;
  logic                                done_d;

  assign cfg_ready = 1'b1;
  assign advance   = sample_valid && (!out_valid || out_ready);
  assign in_ready  = !cfg_busy && (!sample_valid || advance);
  assign sample    = ~sample_q;
  assign pal_idx   = cfg.show_sync ? sample[4:0] : {1'b0, sample[3:0]};

  vspc_cfg #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg         (cfg),
    .restart_col (restart_col),
    .busy        (cfg_busy)
  );

  vspc_addr_gen #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_addr_gen (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .sample        (sample),
    .cfg           (cfg),
    .restart_col   (restart_col),
    .buffer_select (buf_d),
    .pixel_address (addr_d),
    .frame_done    (done_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sample_valid <= 1'b1;
      end else if (advance) begin
        sample_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_q <= raw_sample;
    end
    if (advance) begin
      buffer_select <= buf_d;
      pixel_address <= addr_d;
      pixel_color   <= vspc_pkg::PALETTE[pal_idx];
      frame_done    <= done_d;
    end
  end

endmodule

// ----- rtl/core/vspc_cfg.sv -----
// Configuration registers and the restart-address column unit.
// Depends on vspc_pkg.
module vspc_cfg #(
  parameter int unsigned LINE_PIXELS = vspc_pkg::LINE_PIXELS,
  localparam int unsigned COL_W = $clog2(LINE_PIXELS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [vspc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vspc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output vspc_pkg::cfg_t                      cfg,
  output logic [COL_W-1:0]                    restart_col,
  output logic                                busy
);

  localparam int unsigned ADDR_W      = vspc_pkg::ADDR_W;
  localparam int unsigned RECIP_SHIFT = ADDR_W + $clog2(LINE_PIXELS);
  localparam int unsigned RECIP_W     = ADDR_W + 1;
  localparam int unsigned PROD_W      = ADDR_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + LINE_PIXELS - 1) / LINE_PIXELS;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [ADDR_W-1:0] FRAME_LIMIT = ADDR_W'(vspc_pkg::FRAME_PIXELS);
  localparam logic [ADDR_W-1:0] RESTART_EFF_RST =
    (vspc_pkg::RESTART_RST < FRAME_LIMIT) ? vspc_pkg::RESTART_RST : '0;
  localparam logic [COL_W-1:0] RESTART_COL_RST =
    COL_W'(RESTART_EFF_RST % LINE_PIXELS);

  logic              show_sync;
  logic [7:0]        hsync_run;
  logic [7:0]        vsync_run;
  logic [ADDR_W-1:0] restart_raw;
  logic [ADDR_W-1:0] restart_eff;
  logic [ADDR_W-1:0] restart_quot;
  logic              pend1;
  logic              pend2;

  logic [ADDR_W-1:0] restart_clamp;
  logic [PROD_W-1:0] restart_prod;
  logic [ADDR_W-1:0] line_base;

  assign restart_clamp = (restart_raw < FRAME_LIMIT) ? restart_raw : '0;
  assign restart_prod  = PROD_W'(restart_clamp) * PROD_W'(RECIP);
  assign line_base     = ADDR_W'(restart_quot * LINE_PIXELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      show_sync   <= vspc_pkg::SHOW_SYNC_RST;
      hsync_run   <= vspc_pkg::HSYNC_RUN_RST;
      vsync_run   <= vspc_pkg::VSYNC_RUN_RST;
      restart_raw <= vspc_pkg::RESTART_RST;
      restart_eff <= RESTART_EFF_RST;
      restart_col <= RESTART_COL_RST;
      pend1       <= 1'b0;
      pend2       <= 1'b0;
    end else begin
      pend1 <= 1'b0;
      pend2 <= pend1;
      if (cfg_write) begin
        unique case (cfg_index)
          vspc_pkg::REG_SHOW_SYNC: show_sync <= cfg_data[0];
          vspc_pkg::REG_HSYNC_RUN: hsync_run <= cfg_data[7:0];
          vspc_pkg::REG_VSYNC_RUN: vsync_run <= cfg_data[7:0];
          vspc_pkg::REG_RESTART: begin
            restart_raw <= cfg_data;
            pend1       <= 1'b1;
          end
          default: ;
        endcase
      end
      if (pend1) begin
        restart_eff <= restart_clamp;
      end
      if (pend2) begin
        restart_col <= COL_W'(restart_eff - line_base);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend1) begin
      restart_quot <= ADDR_W'(restart_prod >> RECIP_SHIFT);
    end
  end

  assign busy = pend1 | pend2;

  always_comb begin
    cfg.show_sync       = show_sync;
    cfg.hsync_run       = hsync_run;
    cfg.vsync_run       = vsync_run;
    cfg.restart_address = restart_eff;
  end

endmodule

// ----- rtl/core/vspc_addr_gen.sv -----
// Write address, line column, zero-run counter and buffer number state.
// Depends on vspc_pkg.
module vspc_addr_gen #(
  parameter int unsigned LINE_PIXELS = vspc_pkg::LINE_PIXELS,
  localparam int unsigned COL_W = $clog2(LINE_PIXELS)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic [vspc_pkg::SAMPLE_W-1:0]    sample,
  input  vspc_pkg::cfg_t                   cfg,
  input  logic [COL_W-1:0]                 restart_col,
  output logic [vspc_pkg::BUF_W-1:0]       buffer_select,
  output logic [vspc_pkg::ADDR_W-1:0]      pixel_address,
  output logic                             frame_done
);

  localparam int unsigned ADDR_W = vspc_pkg::ADDR_W;
  localparam int unsigned BUF_W  = vspc_pkg::BUF_W;
  localparam logic [ADDR_W:0]   FRAME_LIMIT = (ADDR_W+1)'(vspc_pkg::FRAME_PIXELS);
  localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(LINE_PIXELS - 1);
  localparam logic [BUF_W-1:0]  BUF_LAST    = BUF_W'(vspc_pkg::NUM_BUFFERS - 1);

  logic [ADDR_W-1:0] write_address;
  logic [COL_W-1:0]  col;
  logic [7:0]        zero_run_count;
  logic [BUF_W-1:0]  current_buffer;

  logic              hmatch;
  logic              vmatch;
  logic [COL_W-1:0]  col_sel;
  logic [ADDR_W:0]   addr_inc;
  logic [ADDR_W-1:0] write_address_next;
  logic [COL_W-1:0]  col_next;

  assign hmatch = (cfg.hsync_run != '0) && (zero_run_count == cfg.hsync_run);
  assign vmatch = (cfg.vsync_run != '0) && (zero_run_count == cfg.vsync_run);

  always_comb begin
    pixel_address = write_address;
    col_sel       = col;
    if (sample != '0) begin
      priority if (hmatch) begin
        pixel_address = write_address - ADDR_W'(col);
        col_sel       = '0;
      end else if (vmatch) begin
        pixel_address = cfg.restart_address;
        col_sel       = restart_col;
      end else begin
        pixel_address = write_address;
      end
    end
  end

  assign addr_inc   = {1'b0, pixel_address} + (ADDR_W+1)'(1);
  assign frame_done = (addr_inc >= FRAME_LIMIT);
  assign buffer_select = current_buffer;

  always_comb begin
    if (frame_done) begin
      write_address_next = '0;
      col_next           = '0;
    end else begin
      write_address_next = addr_inc[ADDR_W-1:0];
      col_next           = (col_sel == COL_LAST) ? '0 : col_sel + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_address  <= '0;
      col            <= '0;
      zero_run_count <= '0;
      current_buffer <= '0;
    end else if (advance) begin
      write_address <= write_address_next;
      col           <= col_next;
      if (sample == '0) begin
        if (zero_run_count != '1) begin
          zero_run_count <= zero_run_count + 8'd1;
        end
      end else begin
        zero_run_count <= '0;
      end
      if (frame_done) begin
        current_buffer <= (current_buffer == BUF_LAST) ? '0 : current_buffer + BUF_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/vspc_checker.sv -----
// Port-level checks for video_sync_pixel_capture, bound to the top level.
// Depends on vspc_pkg and video_sync_pixel_capture_macros.svh.
`include "video_sync_pixel_capture_macros.svh"

module vspc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [vspc_pkg::BUF_W-1:0]          buffer_select,
  input logic [vspc_pkg::ADDR_W-1:0]         pixel_address,
  input logic [vspc_pkg::COLOR_W-1:0]        pixel_color,
  input logic                                frame_done
);

  localparam logic [vspc_pkg::ADDR_W-1:0] FRAME_LIMIT =
    vspc_pkg::ADDR_W'(vspc_pkg::FRAME_PIXELS);
  localparam logic [vspc_pkg::ADDR_W-1:0] FRAME_LAST =
    vspc_pkg::ADDR_W'(vspc_pkg::FRAME_PIXELS - 1);
  localparam int unsigned RESULT_W =
    vspc_pkg::BUF_W + vspc_pkg::ADDR_W + vspc_pkg::COLOR_W + 1;

  logic                stalled;
  logic                addr_ok;
  logic                done_ok;
  logic [RESULT_W-1:0] result_bits;

  assign stalled     = out_valid && !out_ready;
  assign addr_ok     = pixel_address < FRAME_LIMIT;
  assign done_ok     = frame_done == (pixel_address == FRAME_LAST);
  assign result_bits = {buffer_select, pixel_address, pixel_color, frame_done};

  `VSPC_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "result valid after reset")
  `VSPC_ASSERT(a_addr_in_frame, clk, rst, out_valid |-> addr_ok, "address beyond frame")
  `VSPC_ASSERT(a_done_at_last, clk, rst, out_valid |-> done_ok, "frame end flag mismatch")
  `VSPC_ASSERT(a_out_hold, clk, rst, stalled |=> out_valid && $stable(result_bits), "result moved")

endmodule

bind video_sync_pixel_capture vspc_checker u_vspc_checker (.*);
